### hw/rtl/websocket_frame_deframer_macros.svh
// ----------------------------------------------------------------------------
// WebSocket deframer assertion macros
// Concurrent checks on clk with a synchronous active-low reset; they expand
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define WSD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsd: same-cycle check failed");

// next-cycle implication
`define WSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsd: next-cycle check failed");

`else

`define WSD_ASSERT_IMP(label, ante, cons)
`define WSD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### hw/rtl/wsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int LENGTH_BITS_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int LEN_OUT_W       = 64;

  localparam logic [3:0]  CLOSE_OPCODE = 4'h8;
  localparam logic [3:0]  OPCODE_MASK  = 4'hF;
  localparam logic [6:0]  LEN7_EXT16   = 7'd126;
  localparam logic [6:0]  LEN7_EXT64   = 7'd127;
  localparam logic [15:0] NO_STATUS    = 16'd1005;
  localparam logic [3:0]  EXT16_BYTES  = 4'd2;
  localparam logic [3:0]  EXT64_BYTES  = 4'd8;
  localparam logic [3:0]  KEY_BYTES    = 4'd4;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END     = 2'd1,
    KIND_CLOSE   = 2'd2,
    KIND_DROP    = 2'd3
  } kind_t;

  // All results caused by one input byte; they share opcode and length.
  typedef struct packed {
    logic                 two_res;
    kind_t                kind_a;
    kind_t                kind_b;
    logic [7:0]           data;
    logic [15:0]          status;
    logic [3:0]           opcode;
    logic [LEN_OUT_W-1:0] length;
  } run_t;

  typedef struct packed {
    logic push;
    run_t run;
  } run_req_t;

endpackage

### hw/rtl/wsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_front
// Header parser and unmasker: takes one byte per cycle while the queue is not
// full and builds the run of results that byte causes.
// ----------------------------------------------------------------------------
module wsd_front #(
  parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_buffer_end,
  input  logic              q_full,
  output wsd_pkg::run_req_t req
);
  import wsd_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_LEN     = 6'b000010,
    ST_EXT     = 6'b000100,
    ST_KEY     = 6'b001000,
    ST_PAYLOAD = 6'b010000,
    ST_DONE    = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [3:0]             opcode_r, opcode_nxt;
  logic                   mask_en_r, mask_en_nxt;
  logic [3:0]             hdr_left_r, hdr_left_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [1:0]             mpos_r, mpos_nxt;
  logic [15:0]            cacc_r, cacc_nxt;
  logic [1:0]             cseen_r, cseen_nxt;

  logic       in_acc;
  logic [7:0] key_byte;
  logic [7:0] plain;
  logic       go_len, go_pay;
  logic       emit_pay, emit_fin, emit_drop;
  kind_t      fin_kind;
  logic [15:0] fin_status;

  assign in_stall = q_full;
  assign in_acc   = in_valid && !q_full;

  always_comb begin
    unique case (mpos_r)
      2'd0: key_byte = key_r[31:24];
      2'd1: key_byte = key_r[23:16];
      2'd2: key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign plain = in_data_byte ^ (mask_en_r ? key_byte : 8'h00);

  always_comb begin
    state_nxt    = state_r;
    opcode_nxt   = opcode_r;
    mask_en_nxt  = mask_en_r;
    hdr_left_nxt = hdr_left_r;
    len_nxt      = len_r;
    rem_nxt      = rem_r;
    key_nxt      = key_r;
    mpos_nxt     = mpos_r;
    cacc_nxt     = cacc_r;
    cseen_nxt    = cseen_r;
    go_len       = 1'b0;
    go_pay       = 1'b0;
    emit_pay     = 1'b0;
    emit_fin     = 1'b0;
    emit_drop    = 1'b0;

    if (in_acc) begin
      unique case (state_r)
        ST_IDLE: begin
          opcode_nxt   = in_data_byte[3:0] & OPCODE_MASK;
          mask_en_nxt  = 1'b0;
          hdr_left_nxt = '0;
          len_nxt      = '0;
          rem_nxt      = '0;
          key_nxt      = '0;
          mpos_nxt     = '0;
          cacc_nxt     = '0;
          cseen_nxt    = '0;
          state_nxt    = ST_LEN;
        end
        ST_LEN: begin
          mask_en_nxt = in_data_byte[7];
          if (in_data_byte[6:0] == LEN7_EXT16) begin
            len_nxt      = '0;
            hdr_left_nxt = EXT16_BYTES;
            state_nxt    = ST_EXT;
          end else if (in_data_byte[6:0] == LEN7_EXT64) begin
            len_nxt      = '0;
            hdr_left_nxt = EXT64_BYTES;
            state_nxt    = ST_EXT;
          end else begin
            len_nxt = LENGTH_BITS'(in_data_byte[6:0]);
            go_len  = 1'b1;
          end
        end
        ST_EXT: begin
          // big-endian shift-in, wraps at LENGTH_BITS
          len_nxt = LENGTH_BITS'({len_r, in_data_byte});
          if (hdr_left_r != '0) hdr_left_nxt = hdr_left_r - 4'd1;
          if (hdr_left_nxt == '0) go_len = 1'b1;
        end
        ST_KEY: begin
          key_nxt = {key_r[23:0], in_data_byte};
          if (hdr_left_r != '0) hdr_left_nxt = hdr_left_r - 4'd1;
          if (hdr_left_nxt == '0) go_pay = 1'b1;
        end
        ST_PAYLOAD: begin
          mpos_nxt = mpos_r + 2'd1;
          if (opcode_r == CLOSE_OPCODE) begin
            // only the first two bytes form the close code
            if (cseen_r < 2'd2) begin
              cacc_nxt  = {cacc_r[7:0], plain};
              cseen_nxt = cseen_r + 2'd1;
            end
          end else begin
            emit_pay = 1'b1;
          end
          if (rem_r != '0) rem_nxt = rem_r - LENGTH_BITS'(1);
          if (rem_nxt == '0) begin
            emit_fin  = 1'b1;
            state_nxt = ST_DONE;
          end
        end
        ST_DONE: begin
          state_nxt = ST_DONE;
        end
        default: begin
          state_nxt = ST_DONE;
        end
      endcase

      if (go_len) begin
        if (mask_en_nxt) begin
          key_nxt      = '0;
          hdr_left_nxt = KEY_BYTES;
          state_nxt    = ST_KEY;
        end else begin
          go_pay = 1'b1;
        end
      end

      if (go_pay) begin
        rem_nxt   = len_nxt;
        mpos_nxt  = '0;
        cacc_nxt  = '0;
        cseen_nxt = '0;
        if (len_nxt == '0) begin
          emit_fin  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_PAYLOAD;
        end
      end

      if (in_buffer_end) begin
        emit_drop = (state_nxt != ST_IDLE) && (state_nxt != ST_DONE);
        state_nxt = ST_IDLE;
      end
    end
  end

  assign fin_kind   = (opcode_nxt == CLOSE_OPCODE) ? KIND_CLOSE : KIND_END;
  assign fin_status = (cseen_nxt >= 2'd2) ? cacc_nxt : NO_STATUS;

  // payload+end, payload+drop; end and drop never meet (end leaves DONE)
  always_comb begin
    req.push        = emit_pay || emit_fin || emit_drop;
    req.run.two_res = emit_pay && (emit_fin || emit_drop);
    if (emit_pay) begin
      req.run.kind_a = KIND_PAYLOAD;
    end else if (emit_fin) begin
      req.run.kind_a = fin_kind;
    end else begin
      req.run.kind_a = KIND_DROP;
    end
    req.run.kind_b = emit_fin ? fin_kind : KIND_DROP;
    req.run.data   = plain;
    req.run.status = fin_status;
    req.run.opcode = opcode_nxt;
    req.run.length = LEN_OUT_W'(len_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      opcode_r   <= '0;
      mask_en_r  <= 1'b0;
      hdr_left_r <= '0;
      len_r      <= '0;
      rem_r      <= '0;
      key_r      <= '0;
      mpos_r     <= '0;
      cacc_r     <= '0;
      cseen_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      opcode_r   <= opcode_nxt;
      mask_en_r  <= mask_en_nxt;
      hdr_left_r <= hdr_left_nxt;
      len_r      <= len_nxt;
      rem_r      <= rem_nxt;
      key_r      <= key_nxt;
      mpos_r     <= mpos_nxt;
      cacc_r     <= cacc_nxt;
      cseen_r    <= cseen_nxt;
    end
  end

endmodule

### hw/rtl/wsd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_queue
// Short FIFO of result runs between the parser and the output serializer.
// ----------------------------------------------------------------------------
module wsd_queue #(
  parameter int DEPTH = wsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wsd_pkg::run_req_t req,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output wsd_pkg::run_t     head
);
  import wsd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  run_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = req.push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    if (do_push && !do_pop) count_nxt = count_r + CNT_W'(1);
    if (do_pop && !do_push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= req.run;
  end

endmodule

### hw/rtl/wsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_back
// Output serializer: presents the one or two results of the head run, one
// per request, and frees the run after its last result is taken.
// ----------------------------------------------------------------------------
module wsd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  wsd_pkg::run_t                 head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_payload_byte,
  output logic [3:0]                    out_frame_opcode,
  output logic [wsd_pkg::LEN_OUT_W-1:0] out_frame_length,
  output logic [15:0]                   out_close_status,
  output logic                          out_last_of_run
);
  import wsd_pkg::*;

  logic  sel_r, sel_nxt;
  logic  fire;
  kind_t kind_cur;

  assign kind_cur         = sel_r ? head.kind_b : head.kind_a;
  assign out_valid        = !q_empty;
  assign out_kind         = kind_cur;
  assign out_payload_byte = (kind_cur == KIND_PAYLOAD) ? head.data : 8'h00;
  assign out_close_status = (kind_cur == KIND_CLOSE) ? head.status : 16'h0000;
  assign out_frame_opcode = head.opcode;
  assign out_frame_length = head.length;
  assign out_last_of_run  = sel_r || !head.two_res;

  assign fire    = out_valid && !out_stall;
  assign pop     = fire && out_last_of_run;
  assign sel_nxt = fire ? !out_last_of_run : sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule

### hw/rtl/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser with payload unmasking.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle (in_buffer_end on the last byte of each
// buffer, which must start with a frame header), parses the header, and
// emits unmasked payload bytes, then a message-end or close-received result
// (close code from the first two payload bytes, 1005 when absent). A buffer
// that ends mid-frame adds a frame-dropped result; bytes after a complete
// frame are ignored up to the buffer end. The parser accepts a byte every
// cycle while the queue is not full (in_stall rises only then) and registers
// its results in a QUEUE_DEPTH-entry queue; the output port sends one result
// per cycle while out_stall is low, so a byte that causes two results (last
// payload byte plus end, or payload byte plus drop) takes two transfers.
// Frame lengths wrap to LENGTH_BITS bits and are reported zero-extended.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
  parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_buffer_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_payload_byte,
  output logic [3:0]                    out_frame_opcode,
  output logic [wsd_pkg::LEN_OUT_W-1:0] out_frame_length,
  output logic [15:0]                   out_close_status,
  output logic                          out_last_of_run
);
  import wsd_pkg::*;

  run_req_t req;
  run_t     head;
  logic     q_full, q_empty, pop;

  wsd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_buffer_end(in_buffer_end),
    .q_full       (q_full),
    .req          (req)
  );

  wsd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .pop  (pop),
    .full (q_full),
    .empty(q_empty),
    .head (head)
  );

  wsd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_payload_byte(out_payload_byte),
    .out_frame_opcode(out_frame_opcode),
    .out_frame_length(out_frame_length),
    .out_close_status(out_close_status),
    .out_last_of_run (out_last_of_run)
  );

`include "websocket_frame_deframer_macros.svh"

  `WSD_ASSERT_IMP(a_byte_only_on_payload, out_valid && (out_kind != KIND_PAYLOAD), out_payload_byte == 8'h00)
  `WSD_ASSERT_IMP(a_status_only_on_close, out_valid && (out_kind != KIND_CLOSE), out_close_status == 16'h0000)
  `WSD_ASSERT_IMP(a_drop_ends_run, out_valid && (out_kind == KIND_DROP), out_last_of_run)
  `WSD_ASSERT_NEXT(a_second_is_end_or_drop, out_valid && !out_stall && !out_last_of_run, out_valid && (out_kind != KIND_PAYLOAD))

endmodule
